[rtl/spi_mode0_master_shifter_top_assert.svh]
// assertion macros for the spi mode 0 master shifter
`ifndef SPI_MODE0_MASTER_SHIFTER_TOP_ASSERT_SVH
`define SPI_MODE0_MASTER_SHIFTER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPIM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SPIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/spim_pkg.sv]
package spim_pkg;

  // frame geometry
  localparam int FRAME_BITS = 8;
  localparam int BIT_CNT_W  = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam int BYTE_W     = 8;
  localparam int DELAY_W    = 16;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAME_BITS - 1);

  // request codes
  typedef enum logic [1:0] {
    OP_IDLE     = 2'd0,
    OP_SELECT   = 2'd1,
    OP_DESELECT = 2'd2,
    OP_SWAP     = 2'd3
  } op_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SEL_BUSY   = 2'd1,
    ST_DESEL_FREE = 2'd2,
    ST_SWAP_BUSY  = 2'd3
  } status_t;

  // four phases of one bit, one-hot
  typedef enum logic [3:0] {
    PH_DATA   = 4'b0001,
    PH_RISE   = 4'b0010,
    PH_SAMPLE = 4'b0100,
    PH_FALL   = 4'b1000
  } phase_t;

  // one result item
  typedef struct packed {
    logic              cs_n;
    logic              sclk;
    logic              mosi;
    logic              claimed;
    logic              shifting;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    status_t           status;
  } res_t;

  // byte into the low bits of a frame
  function automatic logic [FRAME_BITS-1:0] frame_from_byte(input logic [BYTE_W-1:0] b);
    logic [FRAME_BITS-1:0] f;
    f = '0;
    for (int i = 0; i < FRAME_BITS; i++) begin
      if (i < BYTE_W) begin
        f[i] = b[i];
      end
    end
    return f;
  endfunction

  // low byte of a frame
  function automatic logic [BYTE_W-1:0] byte_from_frame(input logic [FRAME_BITS-1:0] f);
    logic [BYTE_W-1:0] b;
    b = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (i < FRAME_BITS) begin
        b[i] = f[i];
      end
    end
    return b;
  endfunction

endpackage

[rtl/spim_core.sv]
module spim_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            phase_ticks_we,
  input  logic [spim_pkg::DELAY_W-1:0]    phase_ticks_wdata,
  input  logic                            step,
  input  logic [1:0]                      op,
  input  logic [spim_pkg::BYTE_W-1:0]     tx_byte,
  input  logic                            miso_in,
  output spim_pkg::res_t                  res
);
  import spim_pkg::*;

  // bus and shifter state
  logic [DELAY_W-1:0]    phase_ticks;
  logic                  claimed;
  logic                  cs_line;
  logic                  sclk_line;
  logic                  mosi_line;
  logic [FRAME_BITS-1:0] shift;
  logic [BIT_CNT_W-1:0]  bit_count;
  phase_t                phase;
  logic [DELAY_W-1:0]    delay;
  logic                  active;

  logic                  claimed_next;
  logic                  cs_line_next;
  logic                  sclk_line_next;
  logic                  mosi_line_next;
  logic [FRAME_BITS-1:0] shift_next;
  logic [BIT_CNT_W-1:0]  bit_count_next;
  phase_t                phase_next;
  logic [DELAY_W-1:0]    delay_next;
  logic                  active_next;
  logic                  done;
  status_t               status;

  // request decode, then one tick of the running transfer
  always_comb begin
    claimed_next   = claimed;
    cs_line_next   = cs_line;
    sclk_line_next = sclk_line;
    mosi_line_next = mosi_line;
    shift_next     = shift;
    bit_count_next = bit_count;
    phase_next     = phase;
    delay_next     = delay;
    active_next    = active;
    done           = 1'b0;
    status         = ST_OK;

    unique case (op)
      OP_SELECT: begin
        if (claimed) begin
          status = ST_SEL_BUSY;
        end else begin
          claimed_next = 1'b1;
          cs_line_next = 1'b0;
        end
      end
      OP_DESELECT: begin
        if (!claimed) begin
          status = ST_DESEL_FREE;
        end else begin
          claimed_next = 1'b0;
          cs_line_next = 1'b1;
        end
      end
      OP_SWAP: begin
        if (active) begin
          status = ST_SWAP_BUSY;
        end else begin
          shift_next     = frame_from_byte(tx_byte);
          bit_count_next = '0;
          phase_next     = PH_DATA;
          delay_next     = '0;
          active_next    = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (active_next) begin
      // phase action on the first tick of the phase
      if (delay_next == '0) begin
        unique case (phase_next)
          PH_DATA:   mosi_line_next = shift_next[FRAME_BITS-1];
          PH_RISE: begin
            shift_next     = {shift_next[FRAME_BITS-2:0], 1'b0};
            sclk_line_next = 1'b1;
          end
          PH_SAMPLE: shift_next[0] = shift_next[0] | miso_in;
          PH_FALL:   sclk_line_next = 1'b0;
          default: begin
          end
        endcase
      end
      // phase end and bit advance
      if (delay_next >= phase_ticks) begin
        delay_next = '0;
        unique case (phase_next)
          PH_DATA:   phase_next = PH_RISE;
          PH_RISE:   phase_next = PH_SAMPLE;
          PH_SAMPLE: phase_next = PH_FALL;
          default: begin
            phase_next = PH_DATA;
            if (bit_count_next == LAST_BIT) begin
              bit_count_next = '0;
              active_next    = 1'b0;
              done           = 1'b1;
            end else begin
              bit_count_next = bit_count_next + BIT_CNT_W'(1);
            end
          end
        endcase
      end else begin
        delay_next = delay_next + DELAY_W'(1);
      end
    end
  end

  // result of this transaction
  always_comb begin
    res.cs_n     = cs_line_next;
    res.sclk     = sclk_line_next;
    res.mosi     = mosi_line_next;
    res.claimed  = claimed_next;
    res.shifting = active_next;
    res.rx_valid = done;
    res.rx_byte  = done ? byte_from_frame(shift_next) : '0;
    res.status   = status;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= '0;
      claimed     <= 1'b0;
      cs_line     <= 1'b1;
      sclk_line   <= 1'b0;
      mosi_line   <= 1'b0;
      shift       <= '0;
      bit_count   <= '0;
      phase       <= PH_DATA;
      delay       <= '0;
      active      <= 1'b0;
    end else begin
      if (phase_ticks_we) begin
        phase_ticks <= phase_ticks_wdata;
      end
      if (step) begin
        claimed   <= claimed_next;
        cs_line   <= cs_line_next;
        sclk_line <= sclk_line_next;
        mosi_line <= mosi_line_next;
        shift     <= shift_next;
        bit_count <= bit_count_next;
        phase     <= phase_next;
        delay     <= delay_next;
        active    <= active_next;
      end
    end
  end

endmodule

[rtl/spi_mode0_master_shifter_top.sv]
// SPI mode 0 master shifter, MSB first. Each accepted input transaction is one
// tick of the bit timing and yields exactly one result transaction carrying the
// chip select, clock and data line levels after that tick, the claim and
// transfer flags, the received byte on the tick a frame completes, and a status
// code for rejected requests. The block takes one transaction per cycle while
// in_ready is high and registers its result; all per-tick work sits between
// the state registers and a result register backed by a one-entry skid stage,
// so in_ready drops only during reset and while the skid stage holds a result
// that the consumer has not yet taken. A bit spans four phases of phase_ticks+1
// ticks each, so a byte takes 32*(phase_ticks+1) input transactions, the swap
// request itself being the first of them.
module spi_mode0_master_shifter_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         phase_ticks_we,
  input  logic [spim_pkg::DELAY_W-1:0] phase_ticks_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [spim_pkg::BYTE_W-1:0]  tx_byte,
  input  logic                         miso_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         cs_n,
  output logic                         sclk_out,
  output logic                         mosi_out,
  output logic                         bus_claimed,
  output logic                         shifting,
  output logic                         rx_valid,
  output logic [spim_pkg::BYTE_W-1:0]  rx_byte,
  output logic [1:0]                   status
);
  import spim_pkg::*;

  logic accept;
  logic out_free;
  res_t res;
  res_t out_data;
  res_t skid_data;
  logic skid_valid;

  // bit timing engine
  spim_core u_core (
    .clk               (clk),
    .rst               (rst),
    .phase_ticks_we    (phase_ticks_we),
    .phase_ticks_wdata (phase_ticks_wdata),
    .step              (accept),
    .op                (op),
    .tx_byte           (tx_byte),
    .miso_in           (miso_in),
    .res               (res)
  );

  // input handshake
  assign in_ready = !skid_valid && !rst;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // result register and skid stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // result register and skid stage payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= res;
      end
    end else if (accept) begin
      skid_data <= res;
    end
  end

  // result ports
  assign cs_n        = out_data.cs_n;
  assign sclk_out    = out_data.sclk;
  assign mosi_out    = out_data.mosi;
  assign bus_claimed = out_data.claimed;
  assign shifting    = out_data.shifting;
  assign rx_valid    = out_data.rx_valid;
  assign rx_byte     = out_data.rx_byte;
  assign status      = out_data.status;

`include "spi_mode0_master_shifter_top_assert.svh"

  `SPIM_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid full while output empty")
  `SPIM_ASSERT_NOW(a_cs_follows_claim, out_valid, cs_n == !bus_claimed, "select vs claim")
  `SPIM_ASSERT_NOW(a_done_ends_transfer, out_valid && rx_valid, !shifting, "done while shifting")
  `SPIM_ASSERT_NEXT(a_accept_lands, accept && out_free, out_valid && !skid_valid, "result lost")

endmodule

[sim/spi_mode0_master_shifter_checker.sv]
module spi_mode0_master_shifter_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         phase_ticks_we,
  input  logic [spim_pkg::DELAY_W-1:0] phase_ticks_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [spim_pkg::BYTE_W-1:0]  tx_byte,
  input  logic                         miso_in,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         cs_n,
  input  logic                         sclk_out,
  input  logic                         mosi_out,
  input  logic                         bus_claimed,
  input  logic                         shifting,
  input  logic                         rx_valid,
  input  logic [spim_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [1:0]                   status,
  output int                           errors,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import spim_pkg::*;

  // shadow copy of the shifter state
  logic [DELAY_W-1:0]    tick_limit;
  logic                  owned;
  logic                  cs_line;
  logic                  sck_line;
  logic                  sdo_line;
  logic [FRAME_BITS-1:0] frame_sr;
  int                    bit_idx;
  phase_t                bit_step;
  logic [DELAY_W-1:0]    tick_cnt;
  logic                  busy;

  // line states expected for transactions still in flight
  res_t line_state_q[$];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      report_mismatch($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    end
  endtask

  // one tick of the mode 0 bit timing
  task automatic step_shifter(input op_t code, input logic [BYTE_W-1:0] tx,
                              input logic sdi, output res_t r);
    status_t st;
    logic    done;
    st = ST_OK;
    done = 1'b0;

    // bus claim and transfer start requests
    case (code)
      OP_SELECT: begin
        if (owned) begin
          st = ST_SEL_BUSY;
        end else begin
          owned = 1'b1;
          cs_line = 1'b0;
        end
      end
      OP_DESELECT: begin
        if (!owned) begin
          st = ST_DESEL_FREE;
        end else begin
          owned = 1'b0;
          cs_line = 1'b1;
        end
      end
      OP_SWAP: begin
        if (busy) begin
          st = ST_SWAP_BUSY;
        end else begin
          frame_sr = FRAME_BITS'(tx);
          bit_idx = 0;
          bit_step = PH_DATA;
          tick_cnt = '0;
          busy = 1'b1;
        end
      end
      default: ;
    endcase

    if (busy) begin
      // phase action happens on the first tick of the phase
      if (tick_cnt == '0) begin
        case (bit_step)
          PH_DATA: sdo_line = frame_sr[FRAME_BITS-1];
          PH_RISE: begin
            frame_sr = frame_sr << 1;
            sck_line = 1'b1;
          end
          PH_SAMPLE: begin
            if (sdi) begin
              frame_sr[0] = 1'b1;
            end
          end
          default: sck_line = 1'b0;
        endcase
      end
      // phase ends once the count reaches or passes the limit
      if (tick_cnt >= tick_limit) begin
        tick_cnt = '0;
        case (bit_step)
          PH_DATA:   bit_step = PH_RISE;
          PH_RISE:   bit_step = PH_SAMPLE;
          PH_SAMPLE: bit_step = PH_FALL;
          default: begin
            bit_step = PH_DATA;
            if (bit_idx + 1 >= FRAME_BITS) begin
              bit_idx = 0;
              busy = 1'b0;
              done = 1'b1;
            end else begin
              bit_idx++;
            end
          end
        endcase
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
    end

    r.cs_n     = cs_line;
    r.sclk     = sck_line;
    r.mosi     = sdo_line;
    r.claimed  = owned;
    r.shifting = busy;
    r.rx_valid = done;
    r.rx_byte  = done ? BYTE_W'(frame_sr) : '0;
    r.status   = st;
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      tick_limit = '0;
      owned = 1'b0;
      cs_line = 1'b1;
      sck_line = 1'b0;
      sdo_line = 1'b0;
      frame_sr = '0;
      bit_idx = 0;
      bit_step = PH_DATA;
      tick_cnt = '0;
      busy = 1'b0;
      line_state_q.delete();
    end else begin
      if (phase_ticks_we) begin
        tick_limit = phase_ticks_wdata;
      end

      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (line_state_q.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = line_state_q.pop_front();
          got.cs_n     = cs_n;
          got.sclk     = sclk_out;
          got.mosi     = mosi_out;
          got.claimed  = bus_claimed;
          got.shifting = shifting;
          got.rx_valid = rx_valid;
          got.rx_byte  = rx_byte;
          got.status   = status_t'(status);
          compare_field("cs_n", want.cs_n, got.cs_n);
          compare_field("sclk_out", want.sclk, got.sclk);
          compare_field("mosi_out", want.mosi, got.mosi);
          compare_field("bus_claimed", want.claimed, got.claimed);
          compare_field("shifting", want.shifting, got.shifting);
          compare_field("rx_valid", want.rx_valid, got.rx_valid);
          compare_field("rx_byte", want.rx_byte, got.rx_byte);
          compare_field("status", want.status, got.status);
        end
      end

      // input transaction advances the shadow state
      if (in_valid && in_ready) begin
        step_shifter(op_t'(op), tx_byte, miso_in, want);
        line_state_q.push_back(want);
      end
    end
    outstanding = line_state_q.size();
  end

endmodule

[sim/spi_mode0_master_shifter_top_tb.sv]
module spi_mode0_master_shifter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spim_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int STALL_LIMIT = 3000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                phase_ticks_we;
  logic [DELAY_W-1:0]  phase_ticks_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          op;
  logic [BYTE_W-1:0]   tx_byte;
  logic                miso_in;
  logic                out_valid;
  logic                out_ready;
  logic                cs_n;
  logic                sclk_out;
  logic                mosi_out;
  logic                bus_claimed;
  logic                shifting;
  logic                rx_valid;
  logic [BYTE_W-1:0]   rx_byte;
  logic [1:0]          status;

  int errors;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #(HALF_PERIOD) clk = ~clk;

  spi_mode0_master_shifter_top dut (
    .clk               (clk),
    .rst               (rst),
    .phase_ticks_we    (phase_ticks_we),
    .phase_ticks_wdata (phase_ticks_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .op                (op),
    .tx_byte           (tx_byte),
    .miso_in           (miso_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .cs_n              (cs_n),
    .sclk_out          (sclk_out),
    .mosi_out          (mosi_out),
    .bus_claimed       (bus_claimed),
    .shifting          (shifting),
    .rx_valid          (rx_valid),
    .rx_byte           (rx_byte),
    .status            (status)
  );

  spi_mode0_master_shifter_checker chk (
    .clk               (clk),
    .rst               (rst),
    .phase_ticks_we    (phase_ticks_we),
    .phase_ticks_wdata (phase_ticks_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .op                (op),
    .tx_byte           (tx_byte),
    .miso_in           (miso_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .cs_n              (cs_n),
    .sclk_out          (sclk_out),
    .mosi_out          (mosi_out),
    .bus_claimed       (bus_claimed),
    .shifting          (shifting),
    .rx_valid          (rx_valid),
    .rx_byte           (rx_byte),
    .status            (status),
    .errors            (errors),
    .outstanding       (outstanding)
  );

  // result side: random stalls, or a long hold counted down here
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("** spi_mode0_master_shifter_top: FAILED **");
    $finish;
  end

  // one tick transaction, with random idle cycles ahead of it
  task automatic send_item(input op_t code, input logic [BYTE_W-1:0] tx, input logic sdi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    tx_byte  <= tx;
    miso_in  <= sdi;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly idle ticks so transfers run, with claim and swap requests mixed in
  task automatic send_random(input int count);
    int   pick;
    op_t  code;
    logic [BYTE_W-1:0] tx;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 66) begin
        code = OP_IDLE;
      end else if (pick < 80) begin
        code = OP_SWAP;
      end else if (pick < 90) begin
        code = OP_SELECT;
      end else begin
        code = OP_DESELECT;
      end
      pick = $urandom_range(15);
      if (pick == 0) begin
        tx = 8'h00;
      end else if (pick == 1) begin
        tx = 8'hFF;
      end else begin
        tx = BYTE_W'($urandom_range(255));
      end
      send_item(code, tx, 1'($urandom_range(1)));
    end
  endtask

  // stop offering and wait for every result to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_phase_ticks(input logic [DELAY_W-1:0] value);
    repeat (2) @(posedge clk);
    phase_ticks_we    <= 1'b1;
    phase_ticks_wdata <= value;
    @(posedge clk);
    phase_ticks_we    <= 1'b0;
  endtask

  initial begin
    phase_ticks_we    = 1'b0;
    phase_ticks_wdata = '0;
    in_valid          = 1'b0;
    op                = OP_IDLE;
    tx_byte           = '0;
    miso_in           = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // claim rules and swap rejection, back to back
    set_phase_ticks(16'd0);
    send_item(OP_DESELECT, 8'h00, 1'b0);
    send_item(OP_SELECT, 8'h00, 1'b0);
    send_item(OP_SELECT, 8'h00, 1'b0);
    send_item(OP_IDLE, 8'h00, 1'b1);
    send_item(OP_SWAP, 8'h00, 1'b1);
    send_item(OP_SWAP, 8'hFF, 1'b1);
    send_item(OP_DESELECT, 8'h00, 1'b0);
    send_item(OP_DESELECT, 8'h00, 1'b0);
    send_item(OP_SELECT, 8'hFF, 1'b1);
    send_item(OP_IDLE, 8'hFF, 1'b0);

    // no idling; long result hold fills the block, then a full pause
    send_random(60);
    hold_left = 250;
    send_random(100);
    drain_results();
    send_random(65);
    drain_results();

    // sender mostly idle
    set_phase_ticks(16'd1);
    send_idle_pct = 83;
    send_random(225);
    drain_results();

    // receiver mostly stalled
    set_phase_ticks(16'd2);
    send_idle_pct = 0;
    recv_stall_pct = 83;
    send_random(225);
    drain_results();

    // widest phase, unclaimed swap, then the limit drops mid-phase
    set_phase_ticks(16'hFFFF);
    recv_stall_pct = 0;
    send_item(OP_DESELECT, 8'h00, 1'b1);
    send_item(OP_SWAP, 8'hFF, 1'b1);
    repeat (10) send_item(OP_IDLE, 8'h5A, 1'b1);
    drain_results();
    set_phase_ticks(16'd0);

    // both sides idling
    send_idle_pct = 38;
    recv_stall_pct = 38;
    send_random(225);
    drain_results();
    repeat (4) @(posedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("** spi_mode0_master_shifter_top: PASSED **");
    end else begin
      $display("** spi_mode0_master_shifter_top: FAILED **");
    end
    $finish;
  end

endmodule
